[design/pfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types, action codes and pixel helpers for the packed 3bpp frame
// store.
// ----------------------------------------------------------------------------
package pfs_pkg;

	localparam int CODE_W = 3;
	localparam int WORD_W = 24;
	localparam int PIXELS_PER_WORD = 8;

	localparam logic [1:0] ACT_READ   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;
	localparam logic [1:0] ACT_RENDER = 2'd3;

	// one code repeated in all eight slots
	localparam logic [WORD_W-1:0] REPEAT8 = 24'h249249;

	typedef struct packed {
		logic capture;
		logic calc;
		logic rd_en;
		logic load;
		logic wr_word;
		logic clr_wr;
		logic cnt_clr;
		logic cnt_inc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       in_frame;
		logic       clear_last;
		logic       res_last;
	} sts_t;

	function automatic logic [WORD_W-1:0] palette(input logic [CODE_W-1:0] code);
		logic [WORD_W-1:0] rgb;
		unique case (code)
			3'd0: rgb = 24'h000000;
			3'd1: rgb = 24'hFF0000;
			3'd2: rgb = 24'h00FF00;
			3'd3: rgb = 24'hFFFF00;
			3'd4: rgb = 24'h0000FF;
			3'd5: rgb = 24'hFF00FF;
			3'd6: rgb = 24'h00FFFF;
			default: rgb = 24'hFFFFFF;
		endcase
		return rgb;
	endfunction

	// pixel 0 sits in the top slot
	function automatic logic [CODE_W-1:0] slot_get(input logic [WORD_W-1:0] w,
	                                               input logic [2:0] sel);
		logic [CODE_W-1:0] r;
		r = '0;
		for (int i = 0; i < PIXELS_PER_WORD; i++) begin
			if (sel == 3'(i))
				r = w[WORD_W-1-CODE_W*i -: CODE_W];
		end
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] slot_put(input logic [WORD_W-1:0] w,
	                                               input logic [2:0] sel,
	                                               input logic [CODE_W-1:0] code);
		logic [WORD_W-1:0] r;
		r = w;
		for (int i = 0; i < PIXELS_PER_WORD; i++) begin
			if (sel == 3'(i))
				r[WORD_W-1-CODE_W*i -: CODE_W] = code;
		end
		return r;
	endfunction

endpackage

[design/pfs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pfs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 6000,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

[design/pfs_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_datapath
// Operand capture, word index and address math, frame RAM, sweep/pixel
// counter and registered result outputs.
// ----------------------------------------------------------------------------
module pfs_datapath #(
	parameter int FRAME_WIDTH = 240,
	parameter int FRAME_HEIGHT = 200
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            action,
	input  logic [7:0]            x,
	input  logic [7:0]            y,
	input  logic [2:0]            color,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_data,
	input  pfs_pkg::cmd_t         cmd,
	output pfs_pkg::sts_t         sts,
	output logic                  strobe,
	output logic [2:0]            pixel_code,
	output logic [23:0]           rgb,
	output logic [23:0]           byte_address,
	output logic                  in_range,
	output logic                  last
);
	import pfs_pkg::*;

	localparam int WPL = (FRAME_WIDTH + 7) / 8;
	localparam int FRAME_WORDS = WPL * FRAME_HEIGHT;
	localparam int IDX_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int CNT_W = (IDX_W > 3) ? IDX_W : 3;

	logic [7:0]        bank_q;
	logic [1:0]        action_q;
	logic [7:0]        x_q;
	logic [7:0]        y_q;
	logic [2:0]        color_q;
	logic [IDX_W-1:0]  idx_q;
	logic [15:0]       off_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] rdata;
	logic [WORD_W-1:0] wdata;
	logic [IDX_W-1:0]  waddr;
	logic [15:0]       idx_full;
	logic [15:0]       offset;
	logic              in_frame;
	logic [2:0]        sel;
	logic [2:0]        code;
	logic              is_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
		end else if (cfg_we) begin
			bank_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			x_q      <= x;
			y_q      <= y;
			color_q  <= color;
		end
		if (cmd.calc) begin
			idx_q <= idx_full[IDX_W-1:0];
			off_q <= offset;
		end
		if (cmd.load)
			word_q <= rdata;
	end

	assign in_frame = ({1'b0, x_q} < 9'(FRAME_WIDTH)) && ({1'b0, y_q} < 9'(FRAME_HEIGHT));
	assign idx_full = 16'(y_q) * 16'(WPL) + 16'(x_q[7:3]);
	// three bytes per word
	assign offset   = idx_full + {idx_full[14:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// sweep writes the fill pattern, otherwise merge the new code into the word
	assign wdata = cmd.clr_wr ? WORD_W'(WORD_W'(color_q) * REPEAT8)
	                          : slot_put(rdata, x_q[2:0], color_q);
	assign waddr = cmd.clr_wr ? cnt_q[IDX_W-1:0] : idx_q;

	pfs_ram #(
		.WIDTH (WORD_W),
		.DEPTH (FRAME_WORDS),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (cmd.clr_wr | cmd.wr_word),
		.waddr(waddr),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign is_clear = (action_q == ACT_CLEAR);
	assign sel = (action_q == ACT_RENDER) ? cnt_q[2:0] : x_q[2:0];

	always_comb begin
		if (is_clear || (in_frame && action_q == ACT_WRITE))
			code = color_q;
		else if (in_frame)
			code = slot_get(word_q, sel);
		else
			code = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pixel_code <= code;
			rgb        <= palette(code);
			in_range   <= is_clear | in_frame;
			last       <= sts.res_last;
			if (is_clear)
				byte_address <= {bank_q, 16'h0000};
			else if (in_frame)
				byte_address <= {bank_q, off_q};
			else
				byte_address <= '0;
		end
	end

	assign sts.action     = action_q;
	assign sts.in_frame   = in_frame;
	assign sts.clear_last = (cnt_q == CNT_W'(FRAME_WORDS - 1));
	assign sts.res_last   = (action_q != ACT_RENDER) || (cnt_q[2:0] == 3'd7);

endmodule

[design/pfs_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_controller
// Sequencer for one action: capture, address, memory read, merge/write,
// clear sweep and result emission.
// ----------------------------------------------------------------------------
module pfs_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pfs_pkg::sts_t sts,
	output pfs_pkg::cmd_t cmd
);
	import pfs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CALC  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_LOAD  = 3'd3;
	localparam logic [2:0] S_CLEAR = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_CALC;
				end
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				priority if (sts.action == ACT_CLEAR) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_CLEAR;
				end else if (!sts.in_frame) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_EMIT;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_LOAD;
			end
			S_LOAD: begin
				cmd.load    = 1'b1;
				cmd.wr_word = (sts.action == ACT_WRITE);
				cmd.cnt_clr = 1'b1;
				state_d     = S_EMIT;
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clear_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = S_EMIT;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_EMIT: begin
				cmd.emit    = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (sts.res_last)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

[design/packed_3bpp_frame_store_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_3bpp_frame_store_top
// Frame of 3-bit pixels packed eight to a 24-bit word, with read, write,
// clear and render-group actions and a bank register for reported addresses.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// command   start, busy               action, x, y, color
// result    strobe (one cycle each)   pixel_code, rgb, byte_address, in_range, last
// config    cfg_valid, cfg_ready      cfg_data (frame_bank)
//
// Read and write of an in-range pixel go through address, RAM read, merge and
// write-back, and emit. Render: eight strobes on consecutive cycles. Clear
// sweeps one RAM word a cycle. busy drops on the cycle the final strobe is
// registered; results cannot be stalled. The frame words are undefined after
// reset until written.
module packed_3bpp_frame_store_top #(
	parameter int FRAME_WIDTH = 240,
	parameter int FRAME_HEIGHT = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [2:0]  color,
	output logic        strobe,
	output logic [2:0]  pixel_code,
	output logic [23:0] rgb,
	output logic [23:0] byte_address,
	output logic        in_range,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import pfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	pfs_controller u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	pfs_datapath #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.action      (action),
		.x           (x),
		.y           (y),
		.color       (color),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.sts         (sts),
		.strobe      (strobe),
		.pixel_code  (pixel_code),
		.rgb         (rgb),
		.byte_address(byte_address),
		.in_range    (in_range),
		.last        (last)
	);

endmodule

[design/pfs_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks on command and result sequencing of the frame store.
// ----------------------------------------------------------------------------
module pfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic [2:0]  pixel_code,
	input logic [23:0] rgb,
	input logic [23:0] byte_address,
	input logic        in_range,
	input logic        last
);

	// a taken command keeps the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after a command was taken");

	// render results come back to back until the last one
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("gap inside a result burst");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("result right after the last of a transaction");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !in_range |-> pixel_code == 3'd0 && rgb == 24'd0 && byte_address == 24'd0)
		else $error("out-of-range result carries nonzero fields");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while idle");

endmodule

bind packed_3bpp_frame_store_top pfs_checker u_pfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.strobe      (strobe),
	.pixel_code  (pixel_code),
	.rgb         (rgb),
	.byte_address(byte_address),
	.in_range    (in_range),
	.last        (last)
);

[tb/packed_3bpp_frame_store_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_3bpp_frame_store_checker
// Watches the command, result and config channels of the frame store, keeps
// a mirror of the packed frame and the bank register, predicts the pixel
// results of every accepted command and compares them in order with the
// strobed results. Reports the error count and the number of results still
// owed.
// ----------------------------------------------------------------------------
module packed_3bpp_frame_store_checker
	import pfs_pkg::*;
#(
	parameter int FRAME_WIDTH = 240,
	parameter int FRAME_HEIGHT = 200
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [2:0]  color,
	input  logic        strobe,
	input  logic [2:0]  pixel_code,
	input  logic [23:0] rgb,
	input  logic [23:0] byte_address,
	input  logic        in_range,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output int          error_count,
	output int          outstanding
);

	localparam int WORDS_PER_LINE = (FRAME_WIDTH + 7) / 8;
	localparam int FRAME_WORDS = WORDS_PER_LINE * FRAME_HEIGHT;

	localparam logic [23:0] COLOUR_RGB [8] = '{
		24'h000000, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
		24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
	};

	typedef struct {
		logic [2:0]  code;
		logic [23:0] rgb;
		logic [23:0] addr;
		logic        in_frame;
		logic        last;
	} pixel_result_t;

	logic [23:0]   frame_mirror [FRAME_WORDS];
	logic [7:0]    bank_mirror;
	pixel_result_t pending_pixels [$];

	task automatic queue_pixel(input logic [2:0] code, input logic [23:0] addr,
	                           input logic in_frame, input logic lst);
		pixel_result_t r;
		r.code = code;
		r.rgb = COLOUR_RGB[code];
		r.addr = addr;
		r.in_frame = in_frame;
		r.last = lst;
		pending_pixels.push_back(r);
	endtask

	task automatic predict_pixels(input logic [1:0] act, input logic [7:0] px,
	                              input logic [7:0] py, input logic [2:0] col);
		logic        in_frame;
		int          word_idx;
		int          shift;
		logic [23:0] addr;
		logic [23:0] word;
		in_frame = (int'(px) < FRAME_WIDTH) && (int'(py) < FRAME_HEIGHT);
		word_idx = 0;
		addr = '0;
		word = '0;
		shift = 21 - 3 * int'(px[2:0]);
		if (in_frame) begin
			word_idx = int'(py) * WORDS_PER_LINE + int'(px[7:3]);
			addr = {bank_mirror, 16'h0000}
			     + 24'(int'(py) * 3 * WORDS_PER_LINE + int'(px[7:3]) * 3);
			word = frame_mirror[word_idx];
		end
		case (act)
			ACT_READ: begin
				if (in_frame)
					queue_pixel(word[shift +: 3], addr, 1'b1, 1'b1);
				else
					queue_pixel(3'd0, 24'h0, 1'b0, 1'b1);
			end
			ACT_WRITE: begin
				if (in_frame) begin
					word[shift +: 3] = col;
					frame_mirror[word_idx] = word;
					queue_pixel(col, addr, 1'b1, 1'b1);
				end else begin
					queue_pixel(3'd0, 24'h0, 1'b0, 1'b1);
				end
			end
			ACT_CLEAR: begin
				for (int i = 0; i < FRAME_WORDS; i++)
					frame_mirror[i] = 24'(col * REPEAT8);
				queue_pixel(col, {bank_mirror, 16'h0000}, 1'b1, 1'b1);
			end
			default: begin
				for (int i = 0; i < 8; i++) begin
					if (in_frame)
						queue_pixel(word[21 - 3 * i +: 3], addr, 1'b1, i == 7);
					else
						queue_pixel(3'd0, 24'h0, 1'b0, i == 7);
				end
			end
		endcase
	endtask

	task automatic check_field(input string field, input logic [23:0] exp_val,
	                           input logic [23:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, actual %0h", field, exp_val, act_val);
			error_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_result_t exp_r;
		if (!arst_n) begin
			bank_mirror = '0;
			error_count = 0;
			pending_pixels.delete();
			outstanding <= 0;
		end else begin
			// retire the oldest result before taking a new command on the same edge
			if (strobe) begin
				if (pending_pixels.size() == 0) begin
					$error("pixel result with nothing expected: code %0d address %0h",
					       pixel_code, byte_address);
					error_count++;
				end else begin
					exp_r = pending_pixels.pop_front();
					check_field("pixel_code", 24'(exp_r.code), 24'(pixel_code));
					check_field("rgb", exp_r.rgb, rgb);
					check_field("byte_address", exp_r.addr, byte_address);
					check_field("in_range", 24'(exp_r.in_frame), 24'(in_range));
					check_field("last", 24'(exp_r.last), 24'(last));
				end
			end
			if (cfg_valid && cfg_ready)
				bank_mirror = cfg_data;
			if (start && !busy)
				predict_pixels(action, x, y, color);
			outstanding <= pending_pixels.size();
		end
	end

endmodule

[tb/packed_3bpp_frame_store_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_3bpp_frame_store_top_tb
// Drives read, write, clear and render commands into the frame store under
// several bank settings, with random gaps between commands, and takes the
// verdict from the checker that runs beside the block.
// ----------------------------------------------------------------------------
module packed_3bpp_frame_store_top_tb;
	import pfs_pkg::*;

	localparam int FRAME_WIDTH = 240;
	localparam int FRAME_HEIGHT = 200;
	localparam int FRAME_WORDS = ((FRAME_WIDTH + 7) / 8) * FRAME_HEIGHT;
	localparam int DIRECTED_CLEARS = 3;
	localparam int RANDOM_CLEARS = 8;
	localparam int PHASE_ITEMS = 100;
	localparam int LIMIT_CYCLES =
		4 * ((DIRECTED_CLEARS + RANDOM_CLEARS) * (FRAME_WORDS + 10) + 450 * 20 + 500);

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [7:0]  x;
	logic [7:0]  y;
	logic [2:0]  color;
	logic        strobe;
	logic [2:0]  pixel_code;
	logic [23:0] rgb;
	logic [23:0] byte_address;
	logic        in_range;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	int          error_count;
	int          outstanding;
	int          cycle_count = 0;
	int          clears_left;
	logic        no_gaps;

	packed_3bpp_frame_store_top #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.x(x),
		.y(y),
		.color(color),
		.strobe(strobe),
		.pixel_code(pixel_code),
		.rgb(rgb),
		.byte_address(byte_address),
		.in_range(in_range),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	packed_3bpp_frame_store_checker #(
		.FRAME_WIDTH(FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.x(x),
		.y(y),
		.color(color),
		.strobe(strobe),
		.pixel_code(pixel_code),
		.rgb(rgb),
		.byte_address(byte_address),
		.in_range(in_range),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.error_count(error_count),
		.outstanding(outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// keep start high across back-to-back commands, drop it only for a gap
	task automatic issue_action(input logic [1:0] act, input logic [7:0] px,
	                            input logic [7:0] py, input logic [2:0] col);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		x <= px;
		y <= py;
		color <= col;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic set_bank(input logic [7:0] bank);
		cfg_valid <= 1'b1;
		cfg_data <= bank;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_action();
		int          r;
		logic [1:0]  act;
		logic [7:0]  px;
		logic [7:0]  py;
		r = $urandom_range(0, 99);
		if (r < 2 && clears_left > 0) begin
			act = ACT_CLEAR;
			clears_left--;
		end else if (r < 40) begin
			act = ACT_WRITE;
		end else if (r < 72) begin
			act = ACT_READ;
		end else begin
			act = ACT_RENDER;
		end
		r = $urandom_range(0, 9);
		if (r < 5) begin
			px = 8'($urandom_range(0, FRAME_WIDTH - 1));
			py = 8'($urandom_range(0, FRAME_HEIGHT - 1));
		end else if (r < 8) begin
			// concentrate on the frame corners so reads hit earlier writes
			px = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
			                          : 8'($urandom_range(FRAME_WIDTH - 16, FRAME_WIDTH - 1));
			py = $urandom_range(0, 1) ? 8'($urandom_range(0, 2))
			                          : 8'($urandom_range(FRAME_HEIGHT - 3, FRAME_HEIGHT - 1));
		end else begin
			px = 8'($urandom);
			py = 8'($urandom);
		end
		issue_action(act, px, py, 3'($urandom));
	endtask

	initial begin
		logic [7:0] bank;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_READ;
		x = '0;
		y = '0;
		color = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		clears_left = RANDOM_CLEARS;
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_bank(8'hFF);
		// the frame is undefined until cleared, so clear first
		issue_action(ACT_CLEAR, 8'd17, 8'd250, 3'd5);
		issue_action(ACT_READ, 8'd0, 8'd0, 3'd0);
		issue_action(ACT_WRITE, 8'd0, 8'd0, 3'd7);
		issue_action(ACT_WRITE, 8'd7, 8'd0, 3'd0);
		issue_action(ACT_WRITE, 8'd239, 8'd199, 3'd3);
		issue_action(ACT_WRITE, 8'd255, 8'd255, 3'd7);
		issue_action(ACT_WRITE, 8'd240, 8'd0, 3'd6);
		issue_action(ACT_WRITE, 8'd0, 8'd200, 3'd6);
		issue_action(ACT_READ, 8'd0, 8'd0, 3'd0);
		issue_action(ACT_READ, 8'd7, 8'd0, 3'd7);
		issue_action(ACT_READ, 8'd239, 8'd199, 3'd0);
		issue_action(ACT_READ, 8'd240, 8'd0, 3'd0);
		issue_action(ACT_READ, 8'd0, 8'd200, 3'd0);
		issue_action(ACT_READ, 8'd255, 8'd255, 3'd0);
		issue_action(ACT_RENDER, 8'd0, 8'd0, 3'd0);
		issue_action(ACT_RENDER, 8'd239, 8'd199, 3'd0);
		issue_action(ACT_RENDER, 8'd240, 8'd5, 3'd0);
		issue_action(ACT_RENDER, 8'd3, 8'd200, 3'd0);
		issue_action(ACT_CLEAR, 8'd255, 8'd255, 3'd0);
		issue_action(ACT_READ, 8'd100, 8'd100, 3'd0);
		issue_action(ACT_CLEAR, 8'd0, 8'd0, 3'd7);
		issue_action(ACT_WRITE, 8'd232, 8'd199, 3'd1);
		issue_action(ACT_RENDER, 8'd235, 8'd199, 3'd0);
		issue_action(ACT_RENDER, 8'd8, 8'd1, 3'd0);
		drain_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: bank = 8'h00;
				3: bank = 8'hFF;
				default: bank = 8'($urandom);
			endcase
			set_bank(bank);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 15) == 0)
					no_gaps = ~no_gaps;
				random_action();
			end
			drain_results();
		end

		repeat (10) @(posedge clk);
		if (error_count == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
